@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the ADPCM frame decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");

// A condition that must be followed in the next cycle by another.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

@@ hdl/dspadpcm_pkg.sv @@
// Types and fixed constants of the ADPCM frame decoder.
// No dependencies; used by the decoder top level.
`default_nettype none

package dspadpcm_pkg;

  localparam int SAMPLES_PER_FRAME = 14;
  localparam int CODE_W            = 4;
  localparam int CODES_W           = CODE_W * SAMPLES_PER_FRAME;
  localparam int SCALE_W           = 4;
  localparam int PRED_W            = 3;
  localparam int COEF_W            = 16;
  localparam int PAIR_W            = 2 * COEF_W;
  localparam int SAMPLE_W          = 16;
  localparam int PROD_W            = 2 * COEF_W;
  localparam int CFG_IDX_W         = 3;
  localparam int CNT_W             = 4;
  localparam int SHAMT_W           = 5;

  // The accumulator holds the code term (up to 2^29) plus two 16x16
  // products plus the rounding term without wrapping.
  localparam int ACC_W             = 34;
  localparam int FRAC_SHIFT        = 11;
  localparam int ROUND_TERM        = 1024;
  localparam int SAMPLE_MAX        = 32767;
  localparam int SAMPLE_MIN        = -32768;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_exp;
    logic [PRED_W-1:0]  predictor;
    logic [CODES_W-1:0] codes;
    logic               clear_history;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm_sample;
    logic                       last_of_frame;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/dsp_adpcm_frame_decoder.sv @@
// Top level of the 4-bit ADPCM frame decoder: sequencer, shared multiplier,
// history and coefficient registers. Depends on dspadpcm_pkg and assert_macros.svh.
`default_nettype none

// One input transaction carries an 8-byte frame (scale exponent, predictor
// index, fourteen 4-bit codes, and a flag that zeroes the history first) and
// produces fourteen output transactions of signed 16-bit saturated samples,
// the fourteenth flagged as last of frame. Each sample runs through the
// sequencer: one 16x16 signed multiplier is shared between the two predictor
// taps in turn, and a finish step adds, rounds, shifts and clamps before the
// sample becomes the history for the next one; the finish step waits while
// the output register still holds an unaccepted sample. A new frame is taken
// only after the last sample of the previous frame has been loaded into
// the output register and the block is idle again. in_ready is high only
// between frames; the last sample of a frame may still wait in the output
// register while the next frame is accepted. The two history samples persist
// across frames and reset to zero. Coefficient pairs are written through the
// cfg port, which is always ready and should be used only while the block is
// idle; writes to an index not below PREDICTOR_COUNT are ignored, and a frame
// that selects such a predictor decodes with both coefficients zero. There is
// no memory and no clearing pass after reset.

module dsp_adpcm_frame_decoder #(
  parameter int PREDICTOR_COUNT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dspadpcm_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dspadpcm_pkg::out_item_t              out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dspadpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dspadpcm_pkg::PAIR_W-1:0]      cfg_data
);

`include "assert_macros.svh"

  localparam int ACC_W   = dspadpcm_pkg::ACC_W;
  localparam int PROD_W  = dspadpcm_pkg::PROD_W;
  localparam int COEF_W  = dspadpcm_pkg::COEF_W;
  localparam int CODES_W = dspadpcm_pkg::CODES_W;
  localparam int CODE_W  = dspadpcm_pkg::CODE_W;
  localparam int CNT_W   = dspadpcm_pkg::CNT_W;
  localparam int SHAMT_W = dspadpcm_pkg::SHAMT_W;
  localparam int SAMPLE_W = dspadpcm_pkg::SAMPLE_W;
  localparam int SHIFT_W = ACC_W - dspadpcm_pkg::FRAC_SHIFT;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(dspadpcm_pkg::SAMPLES_PER_FRAME - 1);
  localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(dspadpcm_pkg::SAMPLE_MAX);
  localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(dspadpcm_pkg::SAMPLE_MIN);

  // Per sample: tap on the older history, tap on the newer history, finish.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dspadpcm_pkg::PAIR_W-1:0] coef_r   [PREDICTOR_COUNT];
  logic [dspadpcm_pkg::PAIR_W-1:0] coef_nxt [PREDICTOR_COUNT];
  logic signed [SAMPLE_W-1:0]      hist1_r, hist1_nxt;
  logic signed [SAMPLE_W-1:0]      hist2_r, hist2_nxt;
  logic signed [COEF_W-1:0]        c0_r, c0_nxt;
  logic signed [COEF_W-1:0]        c1_r, c1_nxt;
  logic [dspadpcm_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [CODES_W-1:0]              codes_r, codes_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0]        prod_r, prod_nxt;
  logic signed [ACC_W-1:0]         acc_r, acc_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dspadpcm_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                            in_fire;
  logic                            out_load;
  logic signed [COEF_W-1:0]        mul_a;
  logic signed [SAMPLE_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]        mul_p;
  logic signed [ACC_W-1:0]         prod_ext;
  logic signed [ACC_W-1:0]         code_ext;
  logic signed [ACC_W-1:0]         code_term;
  logic [SHAMT_W-1:0]              shamt;
  logic signed [ACC_W-1:0]         sum;
  logic signed [SHIFT_W-1:0]       shifted;
  logic signed [SAMPLE_W-1:0]      sample;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // The shared multiplier: older history in the first step, newer in the second.
  always_comb begin
    if (state_r == ST_MUL_A) begin
      mul_a = c1_r;
      mul_b = hist2_r;
    end else begin
      mul_a = c0_r;
      mul_b = hist1_r;
    end
    mul_p = mul_a * mul_b;
  end

  assign prod_ext  = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign code_ext  = {{(ACC_W-CODE_W){codes_r[CODES_W-1]}}, codes_r[CODES_W-1 -: CODE_W]};
  assign shamt     = SHAMT_W'(scale_r) + SHAMT_W'(dspadpcm_pkg::FRAC_SHIFT);
  assign code_term = code_ext <<< shamt;

  // Arithmetic right shift is the floor division by 2^11; then saturate.
  assign sum     = acc_r + prod_ext;
  assign shifted = sum[ACC_W-1:dspadpcm_pkg::FRAC_SHIFT];

  always_comb begin
    if (shifted > SAT_HI) begin
      sample = SAMPLE_W'(dspadpcm_pkg::SAMPLE_MAX);
    end else if (shifted < SAT_LO) begin
      sample = SAMPLE_W'(dspadpcm_pkg::SAMPLE_MIN);
    end else begin
      sample = shifted[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    coef_nxt      = coef_r;
    hist1_nxt     = hist1_r;
    hist2_nxt     = hist2_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    scale_nxt     = scale_r;
    codes_nxt     = codes_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      for (int k = 0; k < PREDICTOR_COUNT; k++) begin
        if (cfg_index == dspadpcm_pkg::CFG_IDX_W'(k)) begin
          coef_nxt[k] = cfg_data;
        end
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          scale_nxt = in_data.scale_exp;
          codes_nxt = in_data.codes;
          cnt_nxt   = '0;
          c0_nxt    = '0;
          c1_nxt    = '0;
          for (int k = 0; k < PREDICTOR_COUNT; k++) begin
            if (in_data.predictor == dspadpcm_pkg::PRED_W'(k)) begin
              c0_nxt = coef_r[k][COEF_W-1:0];
              c1_nxt = coef_r[k][2*COEF_W-1:COEF_W];
            end
          end
          if (in_data.clear_history) begin
            hist1_nxt = '0;
            hist2_nxt = '0;
          end
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        prod_nxt  = mul_p;
        acc_nxt   = code_term + ACC_W'(dspadpcm_pkg::ROUND_TERM);
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        prod_nxt  = mul_p;
        acc_nxt   = sum;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.pcm_sample    = sample;
          out_data_nxt.last_of_frame = (cnt_r == LAST_CNT);
          hist2_nxt                  = hist1_r;
          hist1_nxt                  = sample;
          codes_nxt                  = codes_r << CODE_W;
          cnt_nxt                    = cnt_r + CNT_W'(1);
          state_nxt                  = (cnt_r == LAST_CNT) ? ST_IDLE : ST_MUL_A;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      cnt_r       <= '0;
      for (int k = 0; k < PREDICTOR_COUNT; k++) begin
        coef_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hist1_r     <= hist1_nxt;
      hist2_r     <= hist2_nxt;
      cnt_r       <= cnt_nxt;
      coef_r      <= coef_nxt;
    end
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    scale_r    <= scale_nxt;
    codes_r    <= codes_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new frame always starts its first sample with the count cleared.
  `ASSERT_NEXT(a_frame_start, clk, rst_n, in_fire, (state_r == ST_MUL_A) && (cnt_r == '0))
  // The sample count never runs past the last sample of a frame while busy.
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, (state_r == ST_IDLE) || (cnt_r <= LAST_CNT))
  // The sample just presented is the newest history entry.
  `ASSERT_NEXT(a_hist_follows, clk, rst_n, out_load, hist1_r == out_data.pcm_sample)
  // After the flagged sample is loaded the block is ready for the next frame.
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && (cnt_r == LAST_CNT),
               in_ready && out_data.last_of_frame)

endmodule

`default_nettype wire

@@ bench/dsp_adpcm_frame_decoder_test.sv @@
// Self-checking testbench for the ADPCM frame decoder. It runs directed and random frames under
// random idling and a long output stall, and checks every sample against a decoder model in the bench.
// Depends on dspadpcm_pkg and the dsp_adpcm_frame_decoder RTL.

module dsp_adpcm_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES_PER_FRAME = dspadpcm_pkg::SAMPLES_PER_FRAME;
  localparam int CODE_W            = dspadpcm_pkg::CODE_W;
  localparam int CODES_W           = dspadpcm_pkg::CODES_W;
  localparam int SCALE_W           = dspadpcm_pkg::SCALE_W;
  localparam int PRED_W            = dspadpcm_pkg::PRED_W;
  localparam int COEF_W            = dspadpcm_pkg::COEF_W;
  localparam int PAIR_W            = dspadpcm_pkg::PAIR_W;
  localparam int SAMPLE_W          = dspadpcm_pkg::SAMPLE_W;
  localparam int CFG_IDX_W         = dspadpcm_pkg::CFG_IDX_W;
  localparam int FRAC_SHIFT        = dspadpcm_pkg::FRAC_SHIFT;
  localparam int ROUND_TERM        = dspadpcm_pkg::ROUND_TERM;
  localparam int SAMPLE_MAX        = dspadpcm_pkg::SAMPLE_MAX;
  localparam int SAMPLE_MIN        = dspadpcm_pkg::SAMPLE_MIN;

  localparam int PRED_COUNT     = 8;
  // The quiet-cycle limit covers the long output hold, with plenty of margin over the longest
  // random gap on either side.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int RANDOM_FRAMES  = 120;

  // Coefficient register map: register k holds the coefficient pair for predictor k.
  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_PAIR_0, COEF_PAIR_1, COEF_PAIR_2, COEF_PAIR_3,
    COEF_PAIR_4, COEF_PAIR_5, COEF_PAIR_6, COEF_PAIR_7
  } coef_reg_e;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  dspadpcm_pkg::in_item_t    in_data;
  logic                      out_valid;
  logic                      out_ready;
  dspadpcm_pkg::out_item_t   out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [PAIR_W-1:0]         cfg_data;

  // Model of the decoder state: the coefficient bank as written and the two-sample history.
  logic [PAIR_W-1:0]          coef_bank [PRED_COUNT];
  logic signed [SAMPLE_W-1:0] hist1;
  logic signed [SAMPLE_W-1:0] hist2;

  // The samples that are still owed by the block, oldest first.
  dspadpcm_pkg::out_item_t pending_samples [$];
  // This array stages the next set of coefficient pairs before it is written to the block.
  logic [PAIR_W-1:0] coef_plan [PRED_COUNT];

  int unsigned mismatch_count;
  bit          in_idle_en;
  bit          out_idle_en;
  bit          hold_out;

  dsp_adpcm_frame_decoder #(
    .PREDICTOR_COUNT(PRED_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Most gaps are zero or a few cycles long. An occasional long gap lets the other side run ahead.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // This function decodes one frame with the model and queues its fourteen samples. A wide signed
  // accumulator holds the code term, both taps and the rounding term, so nothing wraps before the
  // clamp. The arithmetic shift of a signed longint rounds toward minus infinity, which gives the
  // floor that the block uses.
  function automatic void decode_frame_samples(input dspadpcm_pkg::in_item_t frame);
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [CODE_W-1:0] code;
    longint                   acc;
    dspadpcm_pkg::out_item_t  sample;
    c0 = '0;
    c1 = '0;
    if (frame.clear_history) begin
      hist1 = '0;
      hist2 = '0;
    end
    // A predictor index at or above the count reads both coefficients as zero. With three index
    // bits and eight pairs, that case cannot occur.
    if (int'(frame.predictor) < PRED_COUNT) begin
      c0 = coef_bank[frame.predictor][COEF_W-1:0];
      c1 = coef_bank[frame.predictor][PAIR_W-1:COEF_W];
    end
    for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
      code = frame.codes[CODES_W - 1 - CODE_W * i -: CODE_W];
      // At exponent 15 the step is +32768. It goes through the shift, so it never turns negative.
      acc = (longint'(code) <<< (int'(frame.scale_exp) + FRAC_SHIFT))
          + longint'(c0) * longint'(hist1)
          + longint'(c1) * longint'(hist2)
          + ROUND_TERM;
      acc = acc >>> FRAC_SHIFT;
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
      sample.pcm_sample    = acc[SAMPLE_W-1:0];
      sample.last_of_frame = (i == SAMPLES_PER_FRAME - 1);
      pending_samples.push_back(sample);
      hist2 = hist1;
      hist1 = acc[SAMPLE_W-1:0];
    end
  endfunction

  function automatic dspadpcm_pkg::in_item_t make_frame(input int scale, input int pred,
                                                        input logic [CODES_W-1:0] codes,
                                                        input bit clear);
    dspadpcm_pkg::in_item_t f;
    f.scale_exp     = SCALE_W'(scale);
    f.predictor     = PRED_W'(pred);
    f.codes         = codes;
    f.clear_history = clear;
    return f;
  endfunction

  // Random frames mostly use moderate step sizes, so the decoded values do not sit at the clamp
  // all the time. A few frames use the top exponents.
  function automatic dspadpcm_pkg::in_item_t random_frame();
    dspadpcm_pkg::in_item_t f;
    logic [63:0]            bits;
    bits    = {$urandom(), $urandom()};
    f.codes = bits[CODES_W-1:0];
    if ($urandom_range(0, 99) < 80) begin
      f.scale_exp = SCALE_W'($urandom_range(0, 11));
    end else begin
      f.scale_exp = SCALE_W'($urandom_range(12, 15));
    end
    f.predictor     = PRED_W'($urandom_range(0, PRED_COUNT - 1));
    f.clear_history = ($urandom_range(0, 7) == 0);
    return f;
  endfunction

  // Most pairs look like real predictor taps, with magnitudes up to 1.0 in Q11. One pair in four
  // is any 32-bit value.
  function automatic logic [PAIR_W-1:0] random_pair();
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    if ($urandom_range(0, 3) == 0) return $urandom();
    c0 = COEF_W'($urandom_range(0, 2047));
    c1 = COEF_W'($urandom_range(0, 2047));
    if ($urandom_range(0, 1) == 1) c0 = -c0;
    if ($urandom_range(0, 1) == 1) c1 = -c1;
    return {c1, c0};
  endfunction

  function automatic logic [PAIR_W-1:0] extreme_pair();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_7FFF;
      1: return 32'h8000_8000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // This task presents one frame at the falling edge and holds it until the block accepts it.
  // The model then records the expected samples, and the sender may idle before the next frame.
  // After acceptance valid stays high until the next falling edge. There the next frame replaces
  // the payload, or the gap lowers valid.
  task automatic send_frame(input dspadpcm_pkg::in_item_t frame);
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = frame;
    do @(posedge clk); while (!in_ready);
    decode_frame_samples(frame);
    gap = in_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_coef(input coef_reg_e idx, input logic [PAIR_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (int'(idx) < PRED_COUNT) coef_bank[idx] = value;
  endtask

  // This task writes all eight registers from coef_plan. The caller makes sure that the block
  // is idle first.
  task automatic load_coefs();
    for (int k = 0; k < PRED_COUNT; k++) write_coef(coef_reg_e'(k), coef_plan[k]);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // This task stops offering frames and waits for every owed sample. Every frame produces
  // fourteen samples, so the block is idle once the last one arrives. The extra cycles only add
  // a margin.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The coefficients still hold their reset value of zero, so only the code term shows; the
  // rounding term drops out in the shift. This test covers the step at exponent 15 with the
  // largest positive and negative codes, and small codes of both signs at exponent 0.
  task automatic test_reset_defaults();
    send_frame(make_frame(0, 0, 56'h00000000000000, 1'b0));
    send_frame(make_frame(15, 3, 56'h77777777777777, 1'b0));
    send_frame(make_frame(15, 7, 56'h88888888888888, 1'b0));
    send_frame(make_frame(15, 5, 56'h1F1F1F1F1F1F1F, 1'b1));
    send_frame(make_frame(0, 6, 56'h1F8F7F0F1F8F7F, 1'b0));
    wait_idle();
  endtask

  // This test uses extreme coefficient pairs against a saturated history, so both products reach
  // about 2^30 and the sum needs the wide accumulator. It also reaches every predictor, clears
  // the history at points in between, and uses the extreme step sizes and codes.
  task automatic test_coef_extremes();
    coef_plan[COEF_PAIR_0] = 32'h7FFF_7FFF;
    coef_plan[COEF_PAIR_1] = 32'h8000_8000;
    coef_plan[COEF_PAIR_2] = 32'h0000_0800;
    coef_plan[COEF_PAIR_3] = 32'hF800_0800;
    coef_plan[COEF_PAIR_4] = 32'hFFFF_FFFF;
    coef_plan[COEF_PAIR_5] = 32'h8000_7FFF;
    coef_plan[COEF_PAIR_6] = 32'h7FFF_8000;
    coef_plan[COEF_PAIR_7] = 32'hFC00_0C00;
    load_coefs();
    send_frame(make_frame(15, 0, 56'h77777777777777, 1'b1));
    send_frame(make_frame(0, 0, 56'h00000000000000, 1'b0));
    send_frame(make_frame(15, 1, 56'h88888888888888, 1'b0));
    send_frame(make_frame(0, 1, 56'h00000000000000, 1'b0));
    send_frame(make_frame(0, 2, 56'h0123456789ABCD, 1'b1));
    send_frame(make_frame(4, 3, 56'hF0F0F0F0F0F0F0, 1'b0));
    send_frame(make_frame(1, 4, 56'h3C5A96E1D2B478, 1'b0));
    send_frame(make_frame(15, 5, 56'h78787878787878, 1'b0));
    send_frame(make_frame(15, 6, 56'h87878787878787, 1'b0));
    send_frame(make_frame(7, 7, 56'h9ABCDEF0123456, 1'b1));
    send_frame(make_frame(0, 2, 56'h00000000000000, 1'b0));
    send_frame(make_frame(11, 3, 56'h7654321FEDCBA9, 1'b0));
    wait_idle();
  endtask

  // Each phase loads a new coefficient bank and then streams random frames. The idling changes
  // from phase to phase: gaps on both sides, on neither side, on the input only, and on the
  // output only. The last phase draws every pair from the extreme values.
  task automatic test_random_frames();
    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < PRED_COUNT; k++) begin
        coef_plan[k] = (phase == 3) ? extreme_pair() : random_pair();
      end
      in_idle_en  = (phase == 0 || phase == 2);
      out_idle_en = (phase == 0 || phase == 3);
      load_coefs();
      for (int n = 0; n < RANDOM_FRAMES; n++) send_frame(random_frame());
      wait_idle();
    end
  endtask

  // The receiver holds off for a long stretch while frames are offered back to back. The output
  // register fills, the decoder stops, and the input stays stalled until the hold ends.
  task automatic test_output_backpressure();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    hold_out    = 1'b1;
    for (int n = 0; n < 6; n++) send_frame(random_frame());
    wait_idle();
  endtask

  // Receiver: out_ready changes at the falling edge. Either a long hold was requested, or
  // random gaps apply while output idling is on.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        gap = out_idle_en ? pick_gap() : 0;
        if (gap == 0) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Checker: each accepted output transaction is compared with the oldest owed sample.
  always @(posedge clk) begin
    dspadpcm_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: expected no sample, actual sample %0d, last_of_frame %0b", $time,
                 out_data.pcm_sample, out_data.last_of_frame);
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        if (out_data.pcm_sample !== want.pcm_sample) begin
          $display("%0t: pcm_sample expected %0d actual %0d", $time,
                   want.pcm_sample, out_data.pcm_sample);
          mismatch_count++;
        end
        if (out_data.last_of_frame !== want.last_of_frame) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $time,
                   want.last_of_frame, out_data.last_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: the run ends if no transaction completes on any channel for too long. This also
  // catches samples that never arrive.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Main sequence. Every input gets a known value at time zero, reset is released at a falling
  // edge, and the tests then run in turn. The model state starts at the reset value of the block.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    hold_out       = 1'b0;
    hist1          = '0;
    hist2          = '0;
    for (int k = 0; k < PRED_COUNT; k++) coef_bank[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_coef_extremes();
    test_random_frames();
    test_output_backpressure();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
